/* sv/typed_work_queue_selective_pop_defines.svh */
// ----------------------------------------------------------------------------
// Typed work queue assertion macros
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TYPED_WORK_QUEUE_SELECTIVE_POP_DEFINES_SVH
`define TYPED_WORK_QUEUE_SELECTIVE_POP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TWQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("twq assertion failed");

// Implication whose consequent is checked in the following cycle.
`define TWQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("twq assertion failed");

`endif

/* sv/twq_pkg.sv */
// ----------------------------------------------------------------------------
// Typed work queue package
// Sizes, request, kind and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package twq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int OWNER_BITS  = 16;
	localparam int AW          = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);

	// Request codes.
	localparam logic [1:0] REQ_PUSH    = 2'd0;
	localparam logic [1:0] REQ_POP     = 2'd1;
	localparam logic [1:0] REQ_REMOVE  = 2'd2;
	localparam logic [1:0] REQ_RELEASE = 2'd3;

	// Entry kinds.
	localparam logic [1:0] KIND_FLUSH        = 2'd0;
	localparam logic [1:0] KIND_REMOVE_LOCAL = 2'd2;

	// Status codes.
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NO_MATCH = 2'd1;
	localparam logic [1:0] STS_FULL     = 2'd2;
	localparam logic [1:0] STS_BAD_KIND = 2'd3;

	typedef struct packed {
		logic [1:0]            kind;
		logic [31:0]           id;
		logic [OWNER_BITS-1:0] owner;
		logic [63:0]           value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/twq_ram.sv */
// ----------------------------------------------------------------------------
// Typed work queue entry RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module twq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/typed_work_queue_selective_pop.sv */
// ----------------------------------------------------------------------------
// Typed work queue with selective pop
// Ordered queue of typed entries with push, masked pop, remove by owner and
// release, plus a pending flush counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done high and cannot be held off.
// Push and release do not raise busy, so the next request may follow at once.
// Pop and remove-by-owner walk every occupied entry through the entry RAM,
// one read per cycle with registered read data, compacting in place.
// ----------------------------------------------------------------------------
module typed_work_queue_selective_pop
	import twq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        retain_time_we,
	input  logic [31:0] retain_time,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  push_kind,
	input  logic [3:0]  type_mask,
	input  logic [31:0] work_id,
	input  logic [15:0] owner_handle,
	input  logic [63:0] push_value,
	input  logic [63:0] limit,
	input  logic [63:0] current_time,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [1:0]  out_kind,
	output logic [31:0] out_id,
	output logic [15:0] out_owner,
	output logic [63:0] out_value,
	output logic [4:0]  removed_count,
	output logic [31:0] flush_count,
	output logic        flush_done,
	output logic        flush_queued
);

	`include "typed_work_queue_selective_pop_defines.svh"

	typedef enum logic {IDLE, SCAN} state_t;

	state_t                state_q;
	logic [31:0]           retain_q;
	logic [CW-1:0]         occ_q;
	logic [CW-1:0]         fq_q;
	logic [31:0]           pend_q;
	logic [CW-1:0]         rd_q;
	logic [CW-1:0]         wr_q;
	logic [CW-1:0]         removed_q;
	logic                  vld_s1;
	logic                  found_q;
	logic                  is_pop_q;
	logic [3:0]            mask_q;
	logic [63:0]           limit_q;
	logic [OWNER_BITS-1:0] owner_q;

	logic                  accept;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	entry_t                ram_wdata;
	entry_t                rd_entry;
	entry_t                push_entry;
	logic                  entry_match;
	logic                  entry_drop;

	assign busy   = (state_q != IDLE);
	assign accept = start && !busy;

	// Entry formed by a push.
	always_comb begin
		push_entry.kind  = push_kind[1:0];
		push_entry.id    = work_id;
		push_entry.owner = owner_handle[OWNER_BITS-1:0];
		push_entry.value = 64'd0;
		if (push_kind[1:0] == KIND_FLUSH) begin
			push_entry.value = push_value;
		end else if (push_kind[1:0] == KIND_REMOVE_LOCAL) begin
			push_entry.value = current_time + {32'd0, retain_q};
		end
	end

	// Decide whether the entry returned by the RAM leaves the queue.
	always_comb begin
		entry_match = mask_q[rd_entry.kind] &&
			((limit_q == 64'd0) || (rd_entry.value < limit_q));
		if (is_pop_q) begin
			entry_drop = !found_q && entry_match;
		end else begin
			entry_drop = (rd_entry.owner == owner_q);
		end
	end

	// RAM write port: push at the tail, or compaction of kept entries.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = occ_q[AW-1:0];
		ram_wdata = push_entry;
		if (state_q == IDLE) begin
			ram_we = accept && (req_type == REQ_PUSH) && !push_kind[2] &&
				(occ_q != CW'(QUEUE_DEPTH));
		end else begin
			ram_we    = vld_s1 && !entry_drop;
			ram_waddr = wr_q[AW-1:0];
			ram_wdata = rd_entry;
		end
	end

	twq_ram #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(rd_entry)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retain_q <= 32'd0;
		end else if (retain_time_we) begin
			retain_q <= retain_time;
		end
	end

	// Control sequencer, counters and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			occ_q     <= '0;
			fq_q      <= '0;
			pend_q    <= 32'd0;
			rd_q      <= '0;
			wr_q      <= '0;
			removed_q <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			is_pop_q  <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						status    <= STS_OK;
						found     <= 1'b0;
						out_kind  <= 2'd0;
						out_id    <= 32'd0;
						out_owner <= 16'd0;
						out_value <= 64'd0;
						removed_count <= 5'd0;
						flush_count   <= pend_q;
						flush_done    <= (pend_q == 32'd0);
						flush_queued  <= (fq_q != '0);
						mask_q    <= type_mask;
						limit_q   <= limit;
						owner_q   <= owner_handle[OWNER_BITS-1:0];
						rd_q      <= '0;
						wr_q      <= '0;
						removed_q <= '0;
						vld_s1    <= 1'b0;
						found_q   <= 1'b0;
						is_pop_q  <= (req_type == REQ_POP);
						unique case (req_type)
							REQ_PUSH: begin
								done <= 1'b1;
								if (push_kind[2]) begin
									status <= STS_BAD_KIND;
								end else if (occ_q == CW'(QUEUE_DEPTH)) begin
									status <= STS_FULL;
								end else begin
									occ_q <= occ_q + 1'b1;
									if (push_kind[1:0] == KIND_FLUSH) begin
										fq_q          <= fq_q + 1'b1;
										pend_q        <= pend_q + 32'd1;
										flush_count   <= pend_q + 32'd1;
										flush_done    <= (pend_q == 32'hFFFF_FFFF);
										flush_queued  <= 1'b1;
									end
								end
							end
							REQ_RELEASE: begin
								done <= 1'b1;
								if (push_kind[2]) begin
									status <= STS_BAD_KIND;
								end else if (push_kind[1:0] == KIND_FLUSH) begin
									pend_q      <= pend_q - 32'd1;
									flush_count <= pend_q - 32'd1;
									flush_done  <= (pend_q == 32'd1);
								end
							end
							default: begin
								state_q <= SCAN;
							end
						endcase
					end
				end
				SCAN: begin
					// Issue the next read while entries remain.
					if (rd_q < occ_q) begin
						rd_q   <= rd_q + 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					// Judge the entry read in the previous cycle.
					if (vld_s1) begin
						if (entry_drop) begin
							if (rd_entry.kind == KIND_FLUSH) begin
								fq_q <= fq_q - 1'b1;
							end
							if (is_pop_q) begin
								found_q   <= 1'b1;
								out_kind  <= rd_entry.kind;
								out_id    <= rd_entry.id;
								out_owner <= 16'(rd_entry.owner);
								out_value <= rd_entry.value;
							end else begin
								removed_q <= removed_q + 1'b1;
								if (rd_entry.kind == KIND_FLUSH) begin
									pend_q <= pend_q - 32'd1;
								end
							end
						end else begin
							wr_q <= wr_q + 1'b1;
						end
					end
					// All entries judged: commit and report.
					if (!vld_s1 && (rd_q >= occ_q)) begin
						state_q       <= IDLE;
						done          <= 1'b1;
						occ_q         <= wr_q;
						found         <= found_q;
						status        <= (is_pop_q && !found_q) ? STS_NO_MATCH : STS_OK;
						removed_count <= 5'(removed_q);
						flush_count   <= pend_q;
						flush_done    <= (pend_q == 32'd0);
						flush_queued  <= (fq_q != '0);
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`TWQ_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CW'(QUEUE_DEPTH))
	`TWQ_ASSERT_IMP(a_fq_le_occ, state_q == IDLE, fq_q <= occ_q)
	`TWQ_ASSERT_IMP(a_compact_order, state_q == SCAN, wr_q <= rd_q)
	`TWQ_ASSERT_IMP(a_found_ok, done && found, status == STS_OK)
	`TWQ_ASSERT_NEXT(a_scan_busy, accept && (req_type == REQ_POP || req_type == REQ_REMOVE),
		busy && !done)

endmodule
